[rtl/atca_pkg.sv]
package atca_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_ID_WIDTH    = 8;

    // command field encoding
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // class field encoding
    localparam logic CLASS_0 = 1'b0;
    localparam logic CLASS_1 = 1'b1;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

[rtl/atca_ram.sv]
module atca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/atca_queue.sv]
module atca_queue #(
    parameter int QUEUE_DEPTH = atca_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = atca_pkg::DEFAULT_ID_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [ID_WIDTH-1:0]     i_push_id,
    input  logic                    i_pop,
    output atca_pkg::t_queue_status o_status,
    output logic [ID_WIDTH-1:0]     o_head_id
);

    import atca_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_fwd, n_fwd;
    logic [ID_WIDTH-1:0] r_fwd_id;
    logic [ID_WIDTH-1:0] ram_rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_comb begin
        n_head = i_pop  ? ptr_inc(r_head) : r_head;
        n_tail = i_push ? ptr_inc(r_tail) : r_tail;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_ONE;
            2'b01:   n_count = r_count - CNT_ONE;
            default: n_count = r_count;
        endcase
        // RAM read is registered: a write to the entry being read this cycle is forwarded
        n_fwd = i_push && (r_tail == n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_fwd   <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_id <= i_push_id;
    end

    // always read at the next head so the oldest id is ready in the following cycle
    atca_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_push),
        .i_wr_addr (r_tail),
        .i_wr_data (i_push_id),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rd_data)
    );

    assign o_head_id      = r_fwd ? r_fwd_id : ram_rd_data;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);

endmodule

[rtl/alternating_two_class_arbiter.sv]
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_stall    | i_command, i_category, i_requester_id
// result  | out       | o_valid / i_stall    | o_grant_valid, o_grant_id, o_grant_class,
//         |           |                      | o_queued, o_rejected
//
// One transaction per cycle sustained while i_stall is low. An accepted transaction
// passes the input register, then the result register. Queue heads come from a
// registered RAM read at the next head, with a forward path for a same-cycle write.
// Reset: synchronous, active low; resource free, both queues empty, no clearing pass.
// A stalled result holds the buffered input transaction; o_stall then rises.
module alternating_two_class_arbiter #(
    parameter int QUEUE_DEPTH = atca_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = atca_pkg::DEFAULT_ID_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic                i_category,
    input  logic [ID_WIDTH-1:0] i_requester_id,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_grant_valid,
    output logic [ID_WIDTH-1:0] o_grant_id,
    output logic                o_grant_class,
    output logic                o_queued,
    output logic                o_rejected
);

    import atca_pkg::*;

    // input register
    logic                r_in_valid;
    logic                r_in_cmd;
    logic                r_in_cat;
    logic [ID_WIDTH-1:0] r_in_id;

    // arbitration state
    logic r_busy, n_busy;
    logic r_holder, n_holder;

    // result register
    logic                r_out_valid;
    logic                r_grant_valid, n_grant_valid;
    logic [ID_WIDTH-1:0] r_grant_id, n_grant_id;
    logic                r_grant_class, n_grant_class;
    logic                r_queued, n_queued;
    logic                r_rejected, n_rejected;

    logic                advance;
    logic                fire;
    logic                in_take;
    logic                other;
    logic [1:0]          push;
    logic [1:0]          pop;
    t_queue_status       q_status [2];
    logic [ID_WIDTH-1:0] q_head_id [2];

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;
    assign other   = ~r_holder;

    always_comb begin
        n_busy        = r_busy;
        n_holder      = r_holder;
        n_grant_valid = 1'b0;
        n_grant_id    = '0;
        n_grant_class = CLASS_0;
        n_queued      = 1'b0;
        n_rejected    = 1'b0;
        push          = 2'b00;
        pop           = 2'b00;
        if (r_in_cmd == CMD_REQUEST) begin
            if (!r_busy) begin
                n_busy        = 1'b1;
                n_holder      = r_in_cat;
                n_grant_valid = 1'b1;
                n_grant_id    = r_in_id;
                n_grant_class = r_in_cat;
            end else if (!q_status[r_in_cat].full) begin
                push[r_in_cat] = fire;
                n_queued       = 1'b1;
            end else begin
                n_rejected = 1'b1;
            end
        end else if (r_busy) begin
            // the other class goes first, then the releaser's own class
            if (!q_status[other].empty) begin
                pop[other]    = fire;
                n_holder      = other;
                n_grant_valid = 1'b1;
                n_grant_id    = q_head_id[other];
                n_grant_class = other;
            end else if (!q_status[r_holder].empty) begin
                pop[r_holder] = fire;
                n_grant_valid = 1'b1;
                n_grant_id    = q_head_id[r_holder];
                n_grant_class = r_holder;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    for (genvar c = 0; c < 2; c++) begin : g_queue
        atca_queue #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .ID_WIDTH    (ID_WIDTH)
        ) u_queue (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_push    (push[c]),
            .i_push_id (r_in_id),
            .i_pop     (pop[c]),
            .o_status  (q_status[c]),
            .o_head_id (q_head_id[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_holder    <= CLASS_0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_busy   <= n_busy;
                r_holder <= n_holder;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd <= i_command;
            r_in_cat <= i_category;
            r_in_id  <= i_requester_id;
        end
        if (fire) begin
            r_grant_valid <= n_grant_valid;
            r_grant_id    <= n_grant_id;
            r_grant_class <= n_grant_class;
            r_queued      <= n_queued;
            r_rejected    <= n_rejected;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_grant_valid = r_grant_valid;
    assign o_grant_id    = r_grant_id;
    assign o_grant_class = r_grant_class;
    assign o_queued      = r_queued;
    assign o_rejected    = r_rejected;

    a_stall_needs_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_idle_request_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_busy && r_in_cmd == CMD_REQUEST) |=> (r_busy && o_grant_valid))
        else $error("request to a free resource not granted");

    a_grant_matches_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_grant_valid) |-> (r_busy && o_grant_class == r_holder))
        else $error("granted class differs from holder");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones({o_grant_valid, o_queued, o_rejected}) <= 1))
        else $error("more than one outcome for a transaction");

endmodule
